// ===== hw/rtl/handshake_connection_table_macros.svh =====
// ----------------------------------------------------------------------------
// Handshake connection table assertion macros
// Short forms for the concurrent checks of the table, clocked on clock and
// disabled during reset.
// ----------------------------------------------------------------------------
`ifndef HANDSHAKE_CONNECTION_TABLE_MACROS_SVH
`define HANDSHAKE_CONNECTION_TABLE_MACROS_SVH

// same-cycle implication
`define HCT_ASSERT_IMP(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HCT_ASSERT_NXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/hct_pkg.sv =====
// ----------------------------------------------------------------------------
// Handshake connection table package
// Field widths, peer and status types and status codes of the table.
// ----------------------------------------------------------------------------
package hct_pkg;

   localparam int STATUS_W = 4;
   localparam int SLOT_W   = 4;
   localparam int IP_W     = 32;
   localparam int PORT_W   = 16;
   localparam int SEQ_W    = 32;
   localparam int PEER_W   = IP_W + PORT_W;

   typedef logic [PEER_W-1:0]   peer_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam logic REQ_SEGMENT = 1'b0;
   localparam logic REQ_ACCEPT  = 1'b1;

   localparam status_type STS_SYNACK    = 4'd0;
   localparam status_type STS_SYN_FULL  = 4'd1;
   localparam status_type STS_SYN_DUP   = 4'd2;
   localparam status_type STS_DONE      = 4'd3;
   localparam status_type STS_NOT_HALF  = 4'd4;
   localparam status_type STS_ALREADY   = 4'd5;
   localparam status_type STS_ACC_FULL  = 4'd6;
   localparam status_type STS_IGNORED   = 4'd7;
   localparam status_type STS_POPPED    = 4'd8;
   localparam status_type STS_NONE      = 4'd9;

endpackage

// ===== hw/rtl/handshake_connection_table.sv =====
// ----------------------------------------------------------------------------
// Handshake connection table
// Listen-side half-open and accepted peer tables with SYN-ACK generation.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction: an arriving segment (req_type 0) or an
//   accept request (req_type 1). rsp_* returns exactly one result per
//   transaction, in order. Both channels use valid/stall.
//   One transaction is worked at a time; req_stall is high while busy.
//   A single compare unit walks one table slot per cycle through the
//   registered read ports of the peer memories. req_stall drops with rsp_valid,
//   so the next transaction can be accepted while that result is presented.
//   Reset clears both valid vectors at once; no clearing pass is needed.
//   A stalled result stays in the output register; the next transaction
//   is accepted meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module handshake_connection_table #(
   parameter int HALF_OPEN_SLOTS = 16,
   parameter int ACCEPT_SLOTS    = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_type,
   input  logic [hct_pkg::IP_W-1:0]      req_src_ip,
   input  logic [hct_pkg::PORT_W-1:0]    req_src_port,
   input  logic                          req_flag_syn,
   input  logic                          req_flag_ack,
   input  logic [hct_pkg::SEQ_W-1:0]     req_seg_seq,
   input  logic [hct_pkg::SEQ_W-1:0]     req_local_isn,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output hct_pkg::status_type           rsp_status,
   output logic                          rsp_reply_valid,
   output logic [hct_pkg::SEQ_W-1:0]     rsp_reply_seq,
   output logic [hct_pkg::SEQ_W-1:0]     rsp_reply_ack,
   output logic [hct_pkg::IP_W-1:0]      rsp_peer_ip,
   output logic [hct_pkg::PORT_W-1:0]    rsp_peer_port,
   output logic [hct_pkg::SLOT_W-1:0]    rsp_slot_index
);
   import hct_pkg::*;

   localparam int HO_IW  = (HALF_OPEN_SLOTS > 1) ? $clog2(HALF_OPEN_SLOTS) : 1;
   localparam int AC_IW  = (ACCEPT_SLOTS > 1) ? $clog2(ACCEPT_SLOTS) : 1;
   localparam int SCAN_W = (HO_IW > AC_IW) ? HO_IW : AC_IW;
   localparam logic [SCAN_W-1:0] HO_LAST = SCAN_W'(HALF_OPEN_SLOTS - 1);
   localparam logic [SCAN_W-1:0] AC_LAST = SCAN_W'(ACCEPT_SLOTS - 1);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_DECIDE = 2'd2;

   localparam logic [1:0] K_POP = 2'd0;
   localparam logic [1:0] K_SYN = 2'd1;
   localparam logic [1:0] K_ACK = 2'd2;
   localparam logic [1:0] K_IGN = 2'd3;

   // peer memories; valid bits live in flops
   peer_type ho_mem [HALF_OPEN_SLOTS];
   peer_type ac_mem [ACCEPT_SLOTS];
   peer_type ho_rd_ff, ac_rd_ff;

   logic [1:0]                 state_ff, state_in;
   logic [1:0]                 kind_ff, kind_in;
   logic                       phase_ff, phase_in;
   peer_type                   key_ff, key_in;
   logic [SEQ_W-1:0]           seq_ff, seq_in;
   logic [SEQ_W-1:0]           isn_ff, isn_in;
   logic [SCAN_W-1:0]          idx_ff, idx_in;
   logic                       issue_ff, issue_in;
   logic                       cmp_vld_ff, cmp_vld_in;
   logic [SCAN_W-1:0]          cmp_idx_ff, cmp_idx_in;
   logic                       hit_ff, hit_in;
   logic [SCAN_W-1:0]          hit_idx_ff, hit_idx_in;
   peer_type                   hit_data_ff, hit_data_in;
   logic                       free_ff, free_in;
   logic [SCAN_W-1:0]          free_idx_ff, free_idx_in;
   logic [SCAN_W-1:0]          ack_slot_ff, ack_slot_in;
   logic [HALF_OPEN_SLOTS-1:0] ho_valid_ff, ho_valid_in;
   logic [ACCEPT_SLOTS-1:0]    ac_valid_ff, ac_valid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   status_type                 rsp_status_ff, rsp_status_in;
   logic                       rsp_reply_valid_ff, rsp_reply_valid_in;
   logic [SEQ_W-1:0]           rsp_reply_seq_ff, rsp_reply_seq_in;
   logic [SEQ_W-1:0]           rsp_reply_ack_ff, rsp_reply_ack_in;
   logic [IP_W-1:0]            rsp_peer_ip_ff, rsp_peer_ip_in;
   logic [PORT_W-1:0]          rsp_peer_port_ff, rsp_peer_port_in;
   logic [SLOT_W-1:0]          rsp_slot_ff, rsp_slot_in;

   logic                       sel_acc, match_any, scan_last;
   logic [SCAN_W-1:0]          last_idx;
   peer_type                   cmp_data;
   logic                       cmp_valid_bit, cmp_match;
   logic                       out_free, req_fire;
   logic                       ho_we, ac_we;
   logic [HO_IW-1:0]           ho_waddr;
   logic [AC_IW-1:0]           ac_waddr;
   logic [SCAN_W+SLOT_W-1:0]   hit_ext, free_ext, ack_ext;
   logic [1:0]                 req_kind;

   assign sel_acc   = (kind_ff == K_POP) || ((kind_ff == K_ACK) && !phase_ff);
   assign match_any = (kind_ff == K_POP);
   assign last_idx  = sel_acc ? AC_LAST : HO_LAST;
   assign scan_last = cmp_vld_ff && (cmp_idx_ff == last_idx);

   // shared compare unit
   assign cmp_data      = sel_acc ? ac_rd_ff : ho_rd_ff;
   assign cmp_valid_bit = sel_acc ? ac_valid_ff[cmp_idx_ff[AC_IW-1:0]]
                                  : ho_valid_ff[cmp_idx_ff[HO_IW-1:0]];
   assign cmp_match     = cmp_valid_bit && (match_any || (cmp_data == key_ff));

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;

   assign hit_ext  = {{SLOT_W{1'b0}}, hit_idx_ff};
   assign free_ext = {{SLOT_W{1'b0}}, free_idx_ff};
   assign ack_ext  = {{SLOT_W{1'b0}}, ack_slot_ff};

   always_comb begin
      if (req_type == REQ_ACCEPT) begin
         req_kind = K_POP;
      end else if (req_flag_syn && !req_flag_ack) begin
         req_kind = K_SYN;
      end else if (!req_flag_syn && req_flag_ack) begin
         req_kind = K_ACK;
      end else begin
         req_kind = K_IGN;
      end
   end

   always_comb begin
      state_in           = state_ff;
      kind_in            = kind_ff;
      phase_in           = phase_ff;
      key_in             = key_ff;
      seq_in             = seq_ff;
      isn_in             = isn_ff;
      idx_in             = idx_ff;
      issue_in           = issue_ff;
      cmp_vld_in         = (state_ff == S_SCAN) && issue_ff;
      cmp_idx_in         = idx_ff;
      hit_in             = hit_ff;
      hit_idx_in         = hit_idx_ff;
      hit_data_in        = hit_data_ff;
      free_in            = free_ff;
      free_idx_in        = free_idx_ff;
      ack_slot_in        = ack_slot_ff;
      ho_valid_in        = ho_valid_ff;
      ac_valid_in        = ac_valid_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_status_in      = rsp_status_ff;
      rsp_reply_valid_in = rsp_reply_valid_ff;
      rsp_reply_seq_in   = rsp_reply_seq_ff;
      rsp_reply_ack_in   = rsp_reply_ack_ff;
      rsp_peer_ip_in     = rsp_peer_ip_ff;
      rsp_peer_port_in   = rsp_peer_port_ff;
      rsp_slot_in        = rsp_slot_ff;
      ho_we              = 1'b0;
      ac_we              = 1'b0;
      ho_waddr           = free_idx_ff[HO_IW-1:0];
      ac_waddr           = ack_slot_ff[AC_IW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               kind_in  = req_kind;
               phase_in = 1'b0;
               key_in   = {req_src_ip, req_src_port};
               seq_in   = req_seg_seq;
               isn_in   = req_local_isn;
               idx_in   = '0;
               issue_in = 1'b1;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               state_in = (req_kind == K_IGN) ? S_DECIDE : S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue_ff) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == last_idx) begin
                  issue_in = 1'b0;
               end
            end
            if (cmp_vld_ff) begin
               if (cmp_match && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_idx_in  = cmp_idx_ff;
                  hit_data_in = cmp_data;
               end
               if (!cmp_valid_bit && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx_ff;
               end
            end
            if (scan_last) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (out_free) begin
               // finish by default; the first ACK pass overrides below
               state_in           = S_IDLE;
               rsp_valid_in       = 1'b1;
               rsp_status_in      = STS_IGNORED;
               rsp_reply_valid_in = 1'b0;
               rsp_reply_seq_in   = '0;
               rsp_reply_ack_in   = '0;
               rsp_peer_ip_in     = '0;
               rsp_peer_port_in   = '0;
               rsp_slot_in        = '0;
               case (kind_ff)
                  K_POP: begin
                     if (hit_ff) begin
                        ac_valid_in[hit_idx_ff[AC_IW-1:0]] = 1'b0;
                        rsp_status_in    = STS_POPPED;
                        rsp_peer_ip_in   = hit_data_ff[PEER_W-1:PORT_W];
                        rsp_peer_port_in = hit_data_ff[PORT_W-1:0];
                        rsp_slot_in      = hit_ext[SLOT_W-1:0];
                     end else begin
                        rsp_status_in = STS_NONE;
                     end
                  end
                  K_SYN: begin
                     if (hit_ff) begin
                        rsp_status_in = STS_SYN_DUP;
                     end else if (!free_ff) begin
                        rsp_status_in = STS_SYN_FULL;
                     end else begin
                        ho_we                                = 1'b1;
                        ho_valid_in[free_idx_ff[HO_IW-1:0]] = 1'b1;
                        rsp_status_in      = STS_SYNACK;
                        rsp_reply_valid_in = 1'b1;
                        rsp_reply_seq_in   = isn_ff;
                        rsp_reply_ack_in   = seq_ff + 1'b1;
                        rsp_slot_in        = free_ext[SLOT_W-1:0];
                     end
                  end
                  K_ACK: begin
                     if (!phase_ff) begin
                        if (hit_ff) begin
                           rsp_status_in = STS_ALREADY;
                        end else if (!free_ff) begin
                           rsp_status_in = STS_ACC_FULL;
                        end else begin
                           // hold the accepted slot, rescan the half-open table
                           rsp_valid_in = rsp_valid_ff && rsp_stall;
                           ack_slot_in  = free_idx_ff;
                           phase_in     = 1'b1;
                           idx_in       = '0;
                           issue_in     = 1'b1;
                           hit_in       = 1'b0;
                           free_in      = 1'b0;
                           state_in     = S_SCAN;
                        end
                     end else if (hit_ff) begin
                        ho_valid_in[hit_idx_ff[HO_IW-1:0]]  = 1'b0;
                        ac_valid_in[ack_slot_ff[AC_IW-1:0]] = 1'b1;
                        ac_we         = 1'b1;
                        rsp_status_in = STS_DONE;
                        rsp_slot_in   = ack_ext[SLOT_W-1:0];
                     end else begin
                        rsp_status_in = STS_NOT_HALF;
                     end
                  end
                  default: begin
                     rsp_status_in = STS_IGNORED;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ho_we) begin
         ho_mem[ho_waddr] <= key_ff;
      end
      ho_rd_ff <= ho_mem[idx_ff[HO_IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (ac_we) begin
         ac_mem[ac_waddr] <= key_ff;
      end
      ac_rd_ff <= ac_mem[idx_ff[AC_IW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_ff     <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         ho_valid_ff  <= '0;
         ac_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issue_ff     <= issue_in;
         cmp_vld_ff   <= cmp_vld_in;
         ho_valid_ff  <= ho_valid_in;
         ac_valid_ff  <= ac_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff            <= kind_in;
      phase_ff           <= phase_in;
      key_ff             <= key_in;
      seq_ff             <= seq_in;
      isn_ff             <= isn_in;
      idx_ff             <= idx_in;
      cmp_idx_ff         <= cmp_idx_in;
      hit_ff             <= hit_in;
      hit_idx_ff         <= hit_idx_in;
      hit_data_ff        <= hit_data_in;
      free_ff            <= free_in;
      free_idx_ff        <= free_idx_in;
      ack_slot_ff        <= ack_slot_in;
      rsp_status_ff      <= rsp_status_in;
      rsp_reply_valid_ff <= rsp_reply_valid_in;
      rsp_reply_seq_ff   <= rsp_reply_seq_in;
      rsp_reply_ack_ff   <= rsp_reply_ack_in;
      rsp_peer_ip_ff     <= rsp_peer_ip_in;
      rsp_peer_port_ff   <= rsp_peer_port_in;
      rsp_slot_ff        <= rsp_slot_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_reply_valid = rsp_reply_valid_ff;
   assign rsp_reply_seq   = rsp_reply_seq_ff;
   assign rsp_reply_ack   = rsp_reply_ack_ff;
   assign rsp_peer_ip     = rsp_peer_ip_ff;
   assign rsp_peer_port   = rsp_peer_port_ff;
   assign rsp_slot_index  = rsp_slot_ff;

`include "handshake_connection_table_macros.svh"

   `HCT_ASSERT_IMP(a_reply_only_synack, rsp_valid_ff,
      rsp_reply_valid_ff == (rsp_status_ff == STS_SYNACK), "reply flag disagrees with status")
   `HCT_ASSERT_NXT(a_busy_after_accept, req_fire, state_ff != S_IDLE,
      "transaction accepted but sequencer stayed idle")
   `HCT_ASSERT_NXT(a_tables_change_on_decide, state_ff != S_DECIDE,
      $stable(ho_valid_ff) && $stable(ac_valid_ff), "table valid bits changed outside decide")
   `HCT_ASSERT_IMP(a_scan_in_range, cmp_vld_ff, cmp_idx_ff <= last_idx,
      "compare index beyond table depth")

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Handshake connection table testbench
// Drives arriving segments and accept requests through the valid/stall
// request channel, keeps its own copy of the half-open and accepted tables
// to predict every response, and compares each response field by field.
// A small peer pool lets the tables fill and drain, so the full, duplicate
// and pop paths all see traffic alongside random noise.
// ----------------------------------------------------------------------------
module testbench;
   import hct_pkg::*;

   localparam int  SLOTS          = 16;
   localparam int  RANDOM_ITEMS   = 1700;
   localparam int  POOL_SIZE      = 40;
   localparam int  LONG_HOLD      = 400;
   localparam int  WATCHDOG_LIMIT = 2000;
   localparam int  DRAIN_CYCLES   = 40;

   typedef struct packed {
      logic              req_type;
      logic [IP_W-1:0]   src_ip;
      logic [PORT_W-1:0] src_port;
      logic              flag_syn;
      logic              flag_ack;
      logic [SEQ_W-1:0]  seg_seq;
      logic [SEQ_W-1:0]  local_isn;
   } table_request_type;

   typedef struct packed {
      status_type        status;
      logic              reply_valid;
      logic [SEQ_W-1:0]  reply_seq;
      logic [SEQ_W-1:0]  reply_ack;
      logic [IP_W-1:0]   peer_ip;
      logic [PORT_W-1:0] peer_port;
      logic [SLOT_W-1:0] slot_index;
   } table_result_type;

   class conn_table_scoreboard;
      bit               half_valid[SLOTS];
      peer_type         half_peer[SLOTS];
      bit               acc_valid[SLOTS];
      peer_type         acc_peer[SLOTS];
      table_result_type awaited_results[$];
      int               errors;

      function new();
         errors = 0;
         for (int i = 0; i < SLOTS; i++) begin
            half_valid[i] = 1'b0;
            half_peer[i]  = '0;
            acc_valid[i]  = 1'b0;
            acc_peer[i]   = '0;
         end
      endfunction

      // only valid entries match; free_slot is -1 when the table is full
      function bit scan_slots(input bit v[SLOTS], input peer_type p[SLOTS],
                              input peer_type key, output int free_slot);
         bit hit;
         hit = 1'b0;
         free_slot = -1;
         for (int i = 0; i < SLOTS; i++) begin
            if (!v[i]) begin
               if (free_slot < 0) free_slot = i;
            end else if (p[i] == key) begin
               hit = 1'b1;
            end
         end
         return hit;
      endfunction

      function void note_request(input table_request_type rq);
         table_result_type rs;
         peer_type         key;
         int               free_slot;
         rs = '0;
         rs.status = STS_IGNORED;
         key = {rq.src_ip, rq.src_port};
         if (rq.req_type == REQ_ACCEPT) begin
            rs.status = STS_NONE;
            for (int i = 0; i < SLOTS; i++) begin
               if (acc_valid[i]) begin
                  rs.peer_ip    = acc_peer[i][PEER_W-1:PORT_W];
                  rs.peer_port  = acc_peer[i][PORT_W-1:0];
                  rs.slot_index = SLOT_W'(i);
                  rs.status     = STS_POPPED;
                  acc_valid[i]  = 1'b0;
                  acc_peer[i]   = '0;
                  break;
               end
            end
         end else if (rq.flag_syn && !rq.flag_ack) begin
            if (scan_slots(half_valid, half_peer, key, free_slot)) begin
               rs.status = STS_SYN_DUP;
            end else if (free_slot < 0) begin
               rs.status = STS_SYN_FULL;
            end else begin
               half_valid[free_slot] = 1'b1;
               half_peer[free_slot]  = key;
               rs.status      = STS_SYNACK;
               rs.reply_valid = 1'b1;
               rs.reply_seq   = rq.local_isn;
               rs.reply_ack   = rq.seg_seq + 1'b1;
               rs.slot_index  = SLOT_W'(free_slot);
            end
         end else if (!rq.flag_syn && rq.flag_ack) begin
            if (scan_slots(acc_valid, acc_peer, key, free_slot)) begin
               rs.status = STS_ALREADY;
            end else if (free_slot < 0) begin
               rs.status = STS_ACC_FULL;
            end else begin
               rs.status = STS_NOT_HALF;
               for (int i = 0; i < SLOTS; i++) begin
                  if (half_valid[i] && half_peer[i] == key) begin
                     half_valid[i] = 1'b0;
                     half_peer[i]  = '0;
                     acc_valid[free_slot] = 1'b1;
                     acc_peer[free_slot]  = key;
                     rs.status     = STS_DONE;
                     rs.slot_index = SLOT_W'(free_slot);
                     break;
                  end
               end
            end
         end
         awaited_results.push_back(rs);
      endfunction

      function void check_result(input table_result_type got);
         table_result_type want;
         if (awaited_results.size() == 0) begin
            $error("response with nothing outstanding: status %0d", got.status);
            errors++;
            return;
         end
         want = awaited_results.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
         end
         if (got.reply_valid !== want.reply_valid) begin
            $error("reply_valid: expected %0d, got %0d", want.reply_valid, got.reply_valid);
            errors++;
         end
         if (got.reply_seq !== want.reply_seq) begin
            $error("reply_seq: expected %h, got %h", want.reply_seq, got.reply_seq);
            errors++;
         end
         if (got.reply_ack !== want.reply_ack) begin
            $error("reply_ack: expected %h, got %h", want.reply_ack, got.reply_ack);
            errors++;
         end
         if (got.peer_ip !== want.peer_ip) begin
            $error("peer_ip: expected %h, got %h", want.peer_ip, got.peer_ip);
            errors++;
         end
         if (got.peer_port !== want.peer_port) begin
            $error("peer_port: expected %h, got %h", want.peer_port, got.peer_port);
            errors++;
         end
         if (got.slot_index !== want.slot_index) begin
            $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
            errors++;
         end
      endfunction
   endclass

   logic              clock           = 1'b0;
   logic              reset           = 1'b1;
   logic              req_valid       = 1'b0;
   logic              req_stall;
   logic              req_type        = 1'b0;
   logic [IP_W-1:0]   req_src_ip      = '0;
   logic [PORT_W-1:0] req_src_port    = '0;
   logic              req_flag_syn    = 1'b0;
   logic              req_flag_ack    = 1'b0;
   logic [SEQ_W-1:0]  req_seg_seq     = '0;
   logic [SEQ_W-1:0]  req_local_isn   = '0;
   logic              rsp_valid;
   logic              rsp_stall       = 1'b0;
   status_type        rsp_status;
   logic              rsp_reply_valid;
   logic [SEQ_W-1:0]  rsp_reply_seq;
   logic [SEQ_W-1:0]  rsp_reply_ack;
   logic [IP_W-1:0]   rsp_peer_ip;
   logic [PORT_W-1:0] rsp_peer_port;
   logic [SLOT_W-1:0] rsp_slot_index;

   conn_table_scoreboard sb = new();
   peer_type             peer_pool[POOL_SIZE];

   handshake_connection_table #(
      .HALF_OPEN_SLOTS(SLOTS),
      .ACCEPT_SLOTS   (SLOTS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_src_ip     (req_src_ip),
      .req_src_port   (req_src_port),
      .req_flag_syn   (req_flag_syn),
      .req_flag_ack   (req_flag_ack),
      .req_seg_seq    (req_seg_seq),
      .req_local_isn  (req_local_isn),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_reply_valid(rsp_reply_valid),
      .rsp_reply_seq  (rsp_reply_seq),
      .rsp_reply_ack  (rsp_reply_ack),
      .rsp_peer_ip    (rsp_peer_ip),
      .rsp_peer_port  (rsp_peer_port),
      .rsp_slot_index (rsp_slot_index)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic table_request_type make_segment(input peer_type peer, input bit syn,
                                                      input bit ack);
      table_request_type rq;
      rq.req_type  = REQ_SEGMENT;
      rq.src_ip    = peer[PEER_W-1:PORT_W];
      rq.src_port  = peer[PORT_W-1:0];
      rq.flag_syn  = syn;
      rq.flag_ack  = ack;
      rq.seg_seq   = $urandom;
      rq.local_isn = $urandom;
      return rq;
   endfunction

   // segment fields carry random junk; the block must ignore them
   function automatic table_request_type make_accept();
      table_request_type rq;
      rq = make_segment({$urandom, 16'($urandom)}, 1'($urandom), 1'($urandom));
      rq.req_type = REQ_ACCEPT;
      return rq;
   endfunction

   // called at a rising edge; returns at the edge that accepts the transaction
   task automatic send_item(input table_request_type rq, input bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= rq.req_type;
      req_src_ip    <= rq.src_ip;
      req_src_port  <= rq.src_port;
      req_flag_syn  <= rq.flag_syn;
      req_flag_ack  <= rq.flag_ack;
      req_seg_seq   <= rq.seg_seq;
      req_local_isn <= rq.local_isn;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(rq);
   endtask

   // stimulus
   initial begin
      table_request_type rq;
      peer_type          p_max;
      peer_type          p_zero;
      peer_type          p_other;
      int                mode;
      int                pick;
      int                idx;
      p_max   = '1;
      p_zero  = '0;
      p_other = {$urandom, 16'($urandom)};
      peer_pool[0] = p_max;
      peer_pool[1] = p_zero;
      peer_pool[2] = {$urandom, 16'($urandom)};
      for (int i = 3; i < POOL_SIZE; i++) begin
         // a few peers share an address and differ only in port
         if (i < 6) peer_pool[i] = {peer_pool[2][PEER_W-1:PORT_W], 16'($urandom)};
         else       peer_pool[i] = {$urandom, 16'($urandom)};
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every path but the two full ones, sequence wrap on the reply
      rq = make_segment(p_max, 1'b1, 1'b0);
      rq.seg_seq = '1;
      rq.local_isn = '1;
      send_item(rq, 1'b0);
      send_item(make_segment(p_max, 1'b1, 1'b0), 1'b0);
      rq = make_segment(p_zero, 1'b1, 1'b0);
      rq.seg_seq = '0;
      rq.local_isn = '0;
      send_item(rq, 1'b0);
      send_item(make_segment(p_other, 1'b0, 1'b1), 1'b0);
      send_item(make_segment(p_max, 1'b0, 1'b1), 1'b0);
      send_item(make_segment(p_max, 1'b0, 1'b1), 1'b0);
      send_item(make_segment(p_other, 1'b1, 1'b1), 1'b0);
      send_item(make_segment(p_other, 1'b0, 1'b0), 1'b0);
      send_item(make_segment(p_max, 1'b1, 1'b0), 1'b0);
      send_item(make_accept(), 1'b0);
      send_item(make_accept(), 1'b0);
      send_item(make_segment(p_zero, 1'b0, 1'b1), 1'b0);
      send_item(make_accept(), 1'b0);
      send_item(make_segment({32'hFFFF_FFFF, 16'h0000}, 1'b1, 1'b0), 1'b0);
      send_item(make_segment({32'h0000_0000, 16'hFFFF}, 1'b1, 1'b0), 1'b0);
      send_item(make_segment(p_max, 1'b0, 1'b1), 1'b1);

      // random: phases alternate between filling, draining and balance
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         mode = (n / 200) % 3;
         idx  = $urandom_range(0, POOL_SIZE - 1);
         if ($urandom_range(0, 99) < 10) begin
            case ($urandom_range(0, 3))
               0: rq = make_segment(peer_pool[idx], 1'b1, 1'b1);
               1: rq = make_segment(peer_pool[idx], 1'b0, 1'b0);
               2: rq = make_segment({$urandom, 16'($urandom)}, 1'($urandom), 1'($urandom));
               default: rq = make_accept();
            endcase
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < (mode == 0 ? 55 : mode == 1 ? 40 : 45))
               rq = make_segment(peer_pool[idx], 1'b1, 1'b0);
            else if (pick < (mode == 0 ? 92 : mode == 1 ? 70 : 80))
               rq = make_segment(peer_pool[idx], 1'b0, 1'b1);
            else
               rq = make_accept();
         end
         send_item(rq, (n / 120) % 5 == 4);
      end
      req_valid <= 1'b0;

      while (sb.awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.awaited_results.size() != 0) begin
         $error("%0d responses never arrived", sb.awaited_results.size());
         sb.errors++;
      end
      if (sb.errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

   // response side: random stall per transaction, quiet stretches, two long holds
   initial begin
      table_result_type got;
      int               wait_left;
      int               taken;
      wait_left = 0;
      taken     = 0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got.status      = rsp_status;
            got.reply_valid = rsp_reply_valid;
            got.reply_seq   = rsp_reply_seq;
            got.reply_ack   = rsp_reply_ack;
            got.peer_ip     = rsp_peer_ip;
            got.peer_port   = rsp_peer_port;
            got.slot_index  = rsp_slot_index;
            sb.check_result(got);
            taken++;
            if (taken == 300 || taken == 1100) wait_left = LONG_HOLD;
            else if ((taken / 150) % 4 == 3)   wait_left = 0;
            else                               wait_left = $urandom_range(0, 3);
         end
         if (wait_left > 0) begin
            rsp_stall <= 1'b1;
            wait_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog: give up after a long stretch with no transaction on either side
   initial begin
      int idle;
      idle = 0;
      while (idle < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle = 0;
         else
            idle++;
      end
      $display("Some tests failed");
      $finish;
   end

endmodule
